[hdl/protobuf_wire_parser_macros.svh]
// ----------------------------------------------------------------------------
// protobuf_wire_parser_macros.svh
// Assertion macros shared by the wire parser modules; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_WIRE_PARSER_MACROS_SVH
`define PROTOBUF_WIRE_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PWP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// next-cycle implication
`define PWP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`else

`define PWP_ASSERT_IMP(label, ante, cons)
`define PWP_ASSERT_NXT(label, ante, cons)

`endif

`endif

[hdl/pwp_pkg.sv]
// ----------------------------------------------------------------------------
// pwp_pkg
// Shared types and constants of the protobuf wire parser.
// ----------------------------------------------------------------------------
package pwp_pkg;

    localparam int unsigned MAX_VARINT_BYTES = 10;
    localparam int unsigned FN_W             = 61;
    localparam int unsigned VAL_W            = 64;

    typedef enum logic [2:0] {
        KIND_SCALAR  = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_TRUNC   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        UNIT_NONE   = 2'd0,
        UNIT_VARINT = 2'd1,
        UNIT_FIXED  = 2'd2
    } unit_t;

    typedef enum logic [1:0] {
        VSEL_ZERO = 2'd0,
        VSEL_ACC  = 2'd1,
        VSEL_BYTE = 2'd2
    } vsel_t;

    // one classified byte, front to back
    typedef struct packed {
        kind_t       kind;
        vsel_t       vsel;
        unit_t       unit;
        logic        is_key;
        logic        done;
        logic        emit;
        logic        id_zero;
        logic        last;
        logic [3:0]  idx;
        logic [7:0]  data;
    } token_t;

    function automatic logic [6:0] group_shift(input logic [3:0] idx);
        return ({3'b000, idx} << 3) - {3'b000, idx};
    endfunction

    function automatic logic [VAL_W-1:0] varint_bits(input logic [7:0] data,
                                                     input logic [3:0] idx);
        return VAL_W'(data[6:0]) << group_shift(idx);
    endfunction

    function automatic logic [VAL_W-1:0] fixed_bits(input logic [7:0] data,
                                                    input logic [3:0] idx);
        return VAL_W'(data) << {idx[2:0], 3'b000};
    endfunction

endpackage

[hdl/pwp_if.sv]
// ----------------------------------------------------------------------------
// pwp_if
// Valid/ready channels: message bytes in, decoded field words out.
// ----------------------------------------------------------------------------
interface pwp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface pwp_field_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [60:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] field_value;
    logic        message_end;

    modport source (output valid, kind, field_number, wire_type, field_value, message_end,
                    input ready);
    modport sink   (input valid, kind, field_number, wire_type, field_value, message_end,
                    output ready);
endinterface

[hdl/pwp_queue.sv]
// ----------------------------------------------------------------------------
// pwp_queue
// Small token FIFO between the byte classifier and the field assembler.
// ----------------------------------------------------------------------------
`include "protobuf_wire_parser_macros.svh"

module pwp_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pwp_pkg::token_t wr_tok,
    output logic            full,
    input  logic            pop,
    output pwp_pkg::token_t rd_tok,
    output logic            empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pwp_pkg::token_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == FULL_CNT);
    assign empty  = (count_reg == '0);
    assign rd_tok = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_tok;
        end
    end

    `PWP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= FULL_CNT)

endmodule

[hdl/pwp_front.sv]
// ----------------------------------------------------------------------------
// pwp_front
// Byte classifier: tracks the field phase, counts bytes, decodes lengths.
// ----------------------------------------------------------------------------
`include "protobuf_wire_parser_macros.svh"

module pwp_front (
    input  logic             clk,
    input  logic             rst_n,
    pwp_byte_if.sink         msg,
    output logic             push,
    output pwp_pkg::token_t  tok,
    input  logic             full
);

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_BYTES  = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;
    localparam logic [3:0] VARINT_LAST = 4'(pwp_pkg::MAX_VARINT_BYTES - 1);
    localparam logic [3:0] FIX64_LAST  = 4'd7;
    localparam logic [3:0] FIX32_LAST  = 4'd3;

    typedef enum logic [5:0] {
        PH_KEY     = 6'b000001,
        PH_VARINT  = 6'b000010,
        PH_FIX64   = 6'b000100,
        PH_FIX32   = 6'b001000,
        PH_LENGTH  = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [2:0]  key_wt_reg, key_wt_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] remain_reg, remain_next;

    logic        accept;
    logic        vdone;
    logic        fdone;
    logic [3:0]  count_inc;
    logic [2:0]  wt_now;
    logic [63:0] len_sum;
    logic [63:0] remain_dec;

    assign msg.ready = !full;
    assign accept    = msg.valid && !full;
    assign push      = accept;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        key_wt_next = key_wt_reg;
        len_next    = len_reg;
        remain_next = remain_reg;

        tok         = '0;
        tok.kind    = pwp_pkg::KIND_SCALAR;
        tok.vsel    = pwp_pkg::VSEL_ZERO;
        tok.unit    = pwp_pkg::UNIT_NONE;
        tok.idx     = count_reg;
        tok.data    = msg.data_byte;
        tok.last    = msg.last_byte;

        vdone      = !msg.data_byte[7] || (count_reg == VARINT_LAST);
        fdone      = (count_reg == ((phase_reg == PH_FIX64) ? FIX64_LAST : FIX32_LAST));
        count_inc  = count_reg + 4'd1;
        wt_now     = (count_reg == 4'd0) ? msg.data_byte[2:0] : key_wt_reg;
        len_sum    = len_reg | pwp_pkg::varint_bits(msg.data_byte, count_reg);
        remain_dec = remain_reg - 64'd1;

        unique case (phase_reg)
            PH_KEY:
            begin
                tok.unit    = pwp_pkg::UNIT_VARINT;
                tok.is_key  = 1'b1;
                tok.done    = vdone;
                key_wt_next = wt_now;
                if (vdone)
                begin
                    count_next = '0;
                    unique case (wt_now)
                        WT_VARINT: phase_next = PH_VARINT;
                        WT_FIX64:  phase_next = PH_FIX64;
                        WT_BYTES:  phase_next = PH_LENGTH;
                        WT_FIX32:  phase_next = PH_FIX32;
                        default:
                        begin
                            tok.emit = 1'b1;
                            tok.kind = pwp_pkg::KIND_UNKNOWN;
                        end
                    endcase
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_VARINT:
            begin
                tok.unit = pwp_pkg::UNIT_VARINT;
                if (vdone)
                begin
                    tok.done   = 1'b1;
                    tok.emit   = 1'b1;
                    tok.vsel   = pwp_pkg::VSEL_ACC;
                    phase_next = PH_KEY;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_FIX64, PH_FIX32:
            begin
                tok.unit = pwp_pkg::UNIT_FIXED;
                if (fdone)
                begin
                    tok.done   = 1'b1;
                    tok.emit   = 1'b1;
                    tok.vsel   = pwp_pkg::VSEL_ACC;
                    phase_next = PH_KEY;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_LENGTH:
            begin
                tok.unit = pwp_pkg::UNIT_VARINT;
                if (vdone)
                begin
                    tok.done    = 1'b1;
                    tok.emit    = 1'b1;
                    tok.kind    = pwp_pkg::KIND_HEADER;
                    tok.vsel    = pwp_pkg::VSEL_ACC;
                    remain_next = len_sum;
                    len_next    = '0;
                    count_next  = '0;
                    phase_next  = (len_sum != 64'd0) ? PH_PAYLOAD : PH_KEY;
                end
                else
                begin
                    len_next   = len_sum;
                    count_next = count_inc;
                end
            end
            PH_PAYLOAD:
            begin
                tok.emit    = 1'b1;
                tok.kind    = pwp_pkg::KIND_PAYLOAD;
                tok.vsel    = pwp_pkg::VSEL_BYTE;
                remain_next = remain_dec;
                if (remain_dec == 64'd0)
                begin
                    phase_next = PH_KEY;
                end
            end
            default:
            begin
                phase_next = PH_KEY;
                count_next = '0;
            end
        endcase

        // final byte: an open field turns into a truncation word
        if (msg.last_byte)
        begin
            if (phase_next != PH_KEY || count_next != 4'd0)
            begin
                tok.emit    = 1'b1;
                tok.kind    = pwp_pkg::KIND_TRUNC;
                tok.vsel    = pwp_pkg::VSEL_ZERO;
                tok.id_zero = (phase_next == PH_KEY);
            end
            phase_next  = PH_KEY;
            count_next  = '0;
            key_wt_next = '0;
            len_next    = '0;
            remain_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_KEY;
            count_reg  <= '0;
            key_wt_reg <= '0;
            len_reg    <= '0;
            remain_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            key_wt_reg <= key_wt_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
        end
    end

    `PWP_ASSERT_IMP(a_count_range, 1'b1, count_reg <= VARINT_LAST)
    `PWP_ASSERT_NXT(a_last_home, accept && msg.last_byte, phase_reg == PH_KEY && count_reg == '0)
    `PWP_ASSERT_IMP(a_payload_left, phase_reg == PH_PAYLOAD, remain_reg != 64'd0)

endmodule

[hdl/pwp_back.sv]
// ----------------------------------------------------------------------------
// pwp_back
// Field assembler: builds keys and values from tokens, drives result words.
// ----------------------------------------------------------------------------
`include "protobuf_wire_parser_macros.svh"

module pwp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  pwp_pkg::token_t  tok,
    input  logic             empty,
    output logic             pop,
    pwp_field_if.source      fld
);

    logic [63:0] acc_reg, acc_next;
    logic [60:0] held_fn_reg, held_fn_next;
    logic [2:0]  held_wt_reg, held_wt_next;

    logic        valid_reg, valid_next;
    logic [2:0]  kind_reg;
    logic [60:0] fn_reg;
    logic [2:0]  wt_reg;
    logic [63:0] val_reg;
    logic        end_reg;

    logic [63:0] add;
    logic [63:0] acc_sum;
    logic [60:0] fn_new;
    logic [2:0]  wt_new;
    logic [63:0] res_val;

    assign pop = !empty && (!valid_reg || fld.ready);

    always_comb
    begin
        unique case (tok.unit)
            pwp_pkg::UNIT_VARINT: add = pwp_pkg::varint_bits(tok.data, tok.idx);
            pwp_pkg::UNIT_FIXED:  add = pwp_pkg::fixed_bits(tok.data, tok.idx);
            default:              add = '0;
        endcase
        acc_sum = acc_reg | add;

        if (tok.is_key && tok.done)
        begin
            fn_new = acc_sum[63:3];
            wt_new = acc_sum[2:0];
        end
        else
        begin
            fn_new = held_fn_reg;
            wt_new = held_wt_reg;
        end

        acc_next     = (tok.done || tok.last) ? '0 : acc_sum;
        held_fn_next = tok.last ? '0 : fn_new;
        held_wt_next = tok.last ? '0 : wt_new;

        unique case (tok.vsel)
            pwp_pkg::VSEL_ACC:  res_val = acc_sum;
            pwp_pkg::VSEL_BYTE: res_val = 64'(tok.data);
            default:            res_val = '0;
        endcase

        if (pop)
        begin
            valid_next = tok.emit;
        end
        else if (fld.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            held_fn_reg <= '0;
            held_wt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                acc_reg     <= acc_next;
                held_fn_reg <= held_fn_next;
                held_wt_reg <= held_wt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && tok.emit)
        begin
            kind_reg <= tok.kind;
            fn_reg   <= tok.id_zero ? '0 : fn_new;
            wt_reg   <= tok.id_zero ? '0 : wt_new;
            val_reg  <= res_val;
            end_reg  <= tok.last;
        end
    end

    assign fld.valid        = valid_reg;
    assign fld.kind         = kind_reg;
    assign fld.field_number = fn_reg;
    assign fld.wire_type    = wt_reg;
    assign fld.field_value  = val_reg;
    assign fld.message_end  = end_reg;

    `PWP_ASSERT_NXT(a_last_clears, pop && tok.last, held_fn_reg == '0 && acc_reg == '0)
    `PWP_ASSERT_IMP(a_trunc_end, valid_reg && kind_reg == pwp_pkg::KIND_TRUNC, end_reg)

endmodule

[hdl/protobuf_wire_parser.sv]
// ----------------------------------------------------------------------------
// protobuf_wire_parser
// Protocol Buffers wire-format decoder, one message byte per word.
//
//   channel  modport  word
//   msg      sink     data_byte, last_byte
//   fld      source   kind, field_number, wire_type, field_value, message_end
//
// Sustained rate is one byte per clock while fld takes each word; a byte
// goes to the token FIFO, then its result word to the output register.
// msg.ready falls only when the token FIFO is full; with bytes back to
// back one token sits in the FIFO, so a stall on fld with a word waiting
// fills the FIFO and drops msg.ready. Reset is asynchronous and needs no
// clearing pass; the first byte after reset is taken as a key.
// ----------------------------------------------------------------------------
module protobuf_wire_parser #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    pwp_byte_if.sink    msg,
    pwp_field_if.source fld
);

    logic            push;
    logic            full;
    logic            pop;
    logic            empty;
    pwp_pkg::token_t wr_tok;
    pwp_pkg::token_t rd_tok;

    pwp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .push  (push),
        .tok   (wr_tok),
        .full  (full)
    );

    pwp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_tok (wr_tok),
        .full   (full),
        .pop    (pop),
        .rd_tok (rd_tok),
        .empty  (empty)
    );

    pwp_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (rd_tok),
        .empty (empty),
        .pop   (pop),
        .fld   (fld)
    );

endmodule
